// File: rtl/core/assert_macros.svh
// Assertion macros shared by the Huffman tree decoder RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define HTD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("htd: assertion failed");
// Condition must never be seen outside reset.
`define HTD_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("htd: forbidden condition seen");
`else
`define HTD_ASSERT(name, clk, rst_n, prop)
`define HTD_ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

// File: rtl/core/htd_pkg.sv
// Shared types and constants for the Huffman tree decoder.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package htd_pkg;

    // Fixed field widths
    localparam int IDX_W       = 9;
    localparam int SYM_W       = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_W       = 32;

    // Default sizes, handed down from the top level
    localparam int DEF_NODE_SLOTS  = 512;
    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_SYMBOL_BITS = 8;

    // One node record: a leaf keeps its symbol in the low bits of left
    typedef struct packed {
        logic             leaf;
        logic [IDX_W-1:0] right;
        logic [IDX_W-1:0] left;
    } node_rec_t;

    // Node memory access: one write and one read port
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        node_rec_t        wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } node_req_t;

    // Pending stack commands
    typedef struct packed {
        logic             clear;
        logic             push;
        logic             pop;
        logic [IDX_W-1:0] push_data;
    } stack_req_t;

    // Pending stack status, top entry prefetched
    typedef struct packed {
        logic             empty;
        logic             full;
        logic [IDX_W-1:0] top_data;
    } stack_stat_t;

    // One result beat
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             err;
    } result_t;

    // Extra phase of an item: walk fetch or parent link
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WALK,
        PH_LINK
    } phase_t;

endpackage

`default_nettype wire

// File: rtl/core/huffman_tree_decoder_unit.sv
// Huffman tree decoder, top level: wires control, node store, pending stack
// and output queue. Depends on htd_pkg and assert_macros.svh.
//
// Usage
//   Input beats on s_axis carry one bit each: tdata[0] is the code bit and
//   tuser marks the first bit of a new stream (tree, count and error clear).
//   The stream opens with a preorder tree; after it, each bit steers a walk
//   and every leaf reached gives one output beat on m_axis: tdata is the
//   byte, tlast marks the byte that reaches symbol_count, tuser flags a bad
//   tree (one beat, then bits are dropped until the next stream start).
//   The user must write symbol_count through cfg_wr_en / cfg_wr_data
//   while idle; the block itself does not enforce this.
// Timing
//   Tree bits need no extra phase, but a leaf's last symbol bit with parents
//   pending adds PH_LINK to write the parent link. Walk code bits add
//   PH_WALK for the node memory read of the child; bits dropped after an
//   error or once the count is reached add none. A byte passes the read
//   register, PH_WALK and the output queue; an error beat only the queue.
// Reset and stall
//   Reset clears the control registers but the walk position and pending
//   link; node and stack memories are left as they are, with no clearing
//   pass. A two-beat output queue absorbs a stalled receiver; besides the
//   PH_WALK and PH_LINK phases, input stalls only when that queue is full.
`default_nettype none
`include "assert_macros.svh"

module huffman_tree_decoder_unit #(
    parameter int NODE_SLOTS  = htd_pkg::DEF_NODE_SLOTS,
    parameter int STACK_DEPTH = htd_pkg::DEF_STACK_DEPTH,
    parameter int SYMBOL_BITS = htd_pkg::DEF_SYMBOL_BITS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [htd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [0] code_bit, rest zero
    input  wire                              s_axis_tuser,   // [0] new_stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [htd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [7:0] symbol
    output logic                             m_axis_tlast,   // last_symbol
    output logic                             m_axis_tuser,   // [0] tree_error
    input  wire                              cfg_wr_en,
    input  wire  [htd_pkg::CFG_W-1:0]        cfg_wr_data
);
    import htd_pkg::*;

    node_req_t   node_req;
    node_rec_t   rd_rec;
    node_rec_t   root_rec;
    stack_req_t  stack_req;
    stack_stat_t stack_stat;
    result_t     res_data;
    result_t     out_data;
    logic        res_push;
    logic        buf_has_room;

    htd_ctrl #(
        .NODE_SLOTS  (NODE_SLOTS),
        .STACK_DEPTH (STACK_DEPTH),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .code_bit     (s_axis_tdata[0]),
        .new_stream   (s_axis_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .buf_has_room (buf_has_room),
        .res_push     (res_push),
        .res_data     (res_data),
        .node_req     (node_req),
        .rd_rec       (rd_rec),
        .root_rec     (root_rec),
        .stack_req    (stack_req),
        .stack_stat   (stack_stat)
    );

    htd_node_store #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_node_store (
        .clk      (clk),
        .req      (node_req),
        .rd_rec   (rd_rec),
        .root_rec (root_rec)
    );

    htd_pending_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_pending_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (stack_req),
        .stat  (stack_stat)
    );

    htd_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .has_room  (buf_has_room),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (out_data)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_data.symbol);
    assign m_axis_tlast = out_data.last;
    assign m_axis_tuser = out_data.err;

    // A push never lands on a full stack
    `HTD_ASSERT(a_stack_no_overflow, clk, rst_n, stack_req.push |-> (stack_req.clear || !stack_stat.full))
    // Room checked at accept still holds when the walk result lands
    `HTD_ASSERT(a_result_room, clk, rst_n, res_push |-> buf_has_room)
    // Node memory ports never both busy: load and walk are exclusive
    `HTD_ASSERT_NEVER(a_node_port_excl, clk, rst_n, node_req.we && node_req.re)
    // A walk fetch blocks input for the read cycle
    `HTD_ASSERT(a_walk_blocks_input, clk, rst_n, node_req.re |=> !s_axis_tready)

endmodule

`default_nettype wire

// File: rtl/core/htd_node_store.sv
// Node table of the decoder: one synchronous memory, registered read port,
// plus a shadow of the root record. Depends on htd_pkg.
`default_nettype none

module htd_node_store #(
    parameter int NODE_SLOTS = htd_pkg::DEF_NODE_SLOTS
) (
    input  wire                clk,
    input  htd_pkg::node_req_t req,
    output htd_pkg::node_rec_t rd_rec,
    output htd_pkg::node_rec_t root_rec
);
    import htd_pkg::*;

    localparam int NODE_AW = $clog2(NODE_SLOTS);

    node_rec_t mem [NODE_SLOTS];
    node_rec_t rd_reg;
    node_rec_t root_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[NODE_AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rd_reg <= mem[req.raddr[NODE_AW-1:0]];
        end
    end

    // Mirror every write to the root so a walk restarts without a read
    always_ff @(posedge clk)
    begin
        if (req.we && (req.waddr == '0))
        begin
            root_reg <= req.wdata;
        end
    end

    assign rd_rec   = rd_reg;
    assign root_rec = root_reg;

endmodule

`default_nettype wire

// File: rtl/core/htd_pending_stack.sv
// Stack of internal nodes waiting for their right child, held in a
// synchronous memory with the top entry prefetched. Depends on htd_pkg.
`default_nettype none

module htd_pending_stack #(
    parameter int STACK_DEPTH = htd_pkg::DEF_STACK_DEPTH
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  htd_pkg::stack_req_t  req,
    output htd_pkg::stack_stat_t stat
);
    import htd_pkg::*;

    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int TOP_W = $clog2(STACK_DEPTH + 1);

    logic [IDX_W-1:0] mem [STACK_DEPTH];
    logic [IDX_W-1:0] rd_reg;
    logic [TOP_W-1:0] top_reg;
    logic [TOP_W-1:0] top_next;
    logic [TOP_W-1:0] top_base;
    logic [SAW-1:0]   rd_addr;

    // Pointer update; a clear takes effect before a push in the same beat
    always_comb
    begin
        top_base = req.clear ? '0 : top_reg;
        top_next = top_base;
        if (req.push)
        begin
            top_next = top_base + TOP_W'(1);
        end
        else if (req.pop)
        begin
            top_next = top_base - TOP_W'(1);
        end
    end

    // Prefetch address: the entry under the pointer
    always_comb
    begin
        if (top_reg == '0)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = SAW'(top_reg - TOP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    // Push write and continuous top read
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[top_base[SAW-1:0]] <= req.push_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign stat.empty    = (top_reg == '0);
    assign stat.full     = (top_reg == TOP_W'(STACK_DEPTH));
    assign stat.top_data = rd_reg;

endmodule

`default_nettype wire

// File: rtl/core/htd_result_buf.sv
// Two-entry output queue that parts the result stream from the decoder.
// Depends on htd_pkg.
`default_nettype none

module htd_result_buf (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  htd_pkg::result_t push_data,
    output logic             has_room,
    output logic             m_valid,
    input  wire              m_ready,
    output htd_pkg::result_t m_data
);
    import htd_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;
    logic       pop;

    assign pop = m_valid && m_ready;

    // Advance the queue
    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                slot0_next = slot1_reg;
                if (push)
                begin
                    slot1_next = push_data;
                end
            end
            else if (push)
            begin
                slot0_next = push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign has_room = (count_reg != 2'd2);
    assign m_valid  = (count_reg != 2'd0);
    assign m_data   = slot0_reg;

endmodule

`default_nettype wire

// File: rtl/core/htd_ctrl.sv
// Decoder control: tree load, parent linking and the code walk, driving the
// node store and pending stack. Depends on htd_pkg.
`default_nettype none

module htd_ctrl #(
    parameter int NODE_SLOTS  = htd_pkg::DEF_NODE_SLOTS,
    parameter int STACK_DEPTH = htd_pkg::DEF_STACK_DEPTH,
    parameter int SYMBOL_BITS = htd_pkg::DEF_SYMBOL_BITS
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire                         code_bit,
    input  wire                         new_stream,
    input  wire                         cfg_wr_en,
    input  wire  [htd_pkg::CFG_W-1:0]   cfg_wr_data,
    input  wire                         buf_has_room,
    output logic                        res_push,
    output htd_pkg::result_t            res_data,
    output htd_pkg::node_req_t          node_req,
    input  htd_pkg::node_rec_t          rd_rec,
    input  htd_pkg::node_rec_t          root_rec,
    output htd_pkg::stack_req_t         stack_req,
    input  htd_pkg::stack_stat_t        stack_stat
);
    import htd_pkg::*;

    localparam int NF_W  = $clog2(NODE_SLOTS + 1);
    localparam int LBC_W = $clog2(SYMBOL_BITS + 1);
    // Keeps the stack sizing visible where overflow is decided
    localparam int STACK_LIMIT = STACK_DEPTH;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               loading_reg;
    logic               loading_next;
    logic [LBC_W-1:0]   leaf_cnt_reg;
    logic [LBC_W-1:0]   leaf_cnt_next;
    logic [SYMBOL_BITS-1:0] leaf_shift_reg;
    logic [SYMBOL_BITS-1:0] leaf_shift_next;
    logic [NF_W-1:0]    nf_reg;
    logic [NF_W-1:0]    nf_next;
    logic [CFG_W-1:0]   emitted_reg;
    logic [CFG_W-1:0]   emitted_next;
    logic               err_reg;
    logic               err_next;
    logic [CFG_W-1:0]   symbol_count_reg;
    node_rec_t          cur_rec_reg;
    node_rec_t          cur_rec_next;
    logic [IDX_W-1:0]   link_addr_reg;
    logic [IDX_W-1:0]   link_addr_next;
    node_rec_t          link_rec_reg;
    node_rec_t          link_rec_next;

    logic               accept;
    logic               start_walk;
    logic               start_link;
    logic               walk_done;
    logic               link_wr;
    logic               raise_err;
    logic               eff_loading;
    logic [LBC_W-1:0]   eff_cnt;
    logic [SYMBOL_BITS-1:0] eff_shift;
    logic [NF_W-1:0]    eff_nf;
    logic [CFG_W-1:0]   eff_emit;
    logic               eff_err;
    logic               eff_empty;
    logic               eff_full;
    logic [NF_W-1:0]    nf_inc;
    logic [SYMBOL_BITS:0] sh_ext;
    logic [LBC_W-1:0]   cnt_dec;

    assign accept = s_valid && s_ready;

    // Phase sequencer: next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_walk)
                begin
                    phase_next = PH_WALK;
                end
                else if (start_link)
                begin
                    phase_next = PH_LINK;
                end
            end
            PH_WALK: phase_next = PH_IDLE;
            PH_LINK: phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // Phase sequencer: outputs
    always_comb
    begin
        s_ready   = 1'b0;
        walk_done = 1'b0;
        link_wr   = 1'b0;
        unique case (phase_reg)
            PH_IDLE: s_ready   = buf_has_room;
            PH_WALK: walk_done = 1'b1;
            PH_LINK: link_wr   = 1'b1;
            default: s_ready   = 1'b0;
        endcase
    end

    // Item processing
    always_comb
    begin
        // Restart the stream before the bit is looked at
        eff_loading = loading_reg;
        eff_cnt     = leaf_cnt_reg;
        eff_shift   = leaf_shift_reg;
        eff_nf      = nf_reg;
        eff_emit    = emitted_reg;
        eff_err     = err_reg;
        eff_empty   = stack_stat.empty;
        eff_full    = stack_stat.full;
        stack_req   = '0;
        if (accept && new_stream)
        begin
            eff_loading     = 1'b1;
            eff_cnt         = '0;
            eff_shift       = '0;
            eff_nf          = '0;
            eff_emit        = '0;
            eff_err         = 1'b0;
            eff_empty       = 1'b1;
            eff_full        = (STACK_LIMIT == 0);
            stack_req.clear = 1'b1;
        end

        loading_next    = eff_loading;
        leaf_cnt_next   = eff_cnt;
        leaf_shift_next = eff_shift;
        nf_next         = eff_nf;
        emitted_next    = eff_emit;
        err_next        = eff_err;
        cur_rec_next    = cur_rec_reg;
        link_addr_next  = link_addr_reg;
        link_rec_next   = link_rec_reg;
        node_req        = '0;
        res_push        = 1'b0;
        res_data        = '0;
        start_walk      = 1'b0;
        start_link      = 1'b0;
        raise_err       = 1'b0;

        nf_inc  = eff_nf + NF_W'(1);
        sh_ext  = {eff_shift, code_bit};
        cnt_dec = eff_cnt - LBC_W'(1);

        if (accept && !eff_err)
        begin
            if (eff_loading)
            begin
                if (eff_cnt == '0)
                begin
                    // Node marker bit
                    if (eff_nf >= NF_W'(NODE_SLOTS))
                    begin
                        raise_err = 1'b1;
                    end
                    else if (code_bit)
                    begin
                        if (eff_nf == '0)
                        begin
                            raise_err = 1'b1;
                        end
                        else
                        begin
                            leaf_cnt_next   = LBC_W'(SYMBOL_BITS);
                            leaf_shift_next = '0;
                        end
                    end
                    else if (eff_full)
                    begin
                        raise_err = 1'b1;
                    end
                    else
                    begin
                        // Internal node: left child is the next slot
                        node_req.we         = 1'b1;
                        node_req.waddr      = IDX_W'(eff_nf);
                        node_req.wdata      = '{leaf: 1'b0, right: '0,
                                                left: IDX_W'(nf_inc)};
                        stack_req.push      = 1'b1;
                        stack_req.push_data = IDX_W'(eff_nf);
                        nf_next             = nf_inc;
                    end
                end
                else
                begin
                    // Symbol bit, MSB first
                    leaf_shift_next = sh_ext[SYMBOL_BITS-1:0];
                    leaf_cnt_next   = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        if (eff_nf < NF_W'(NODE_SLOTS))
                        begin
                            node_req.we    = 1'b1;
                            node_req.waddr = IDX_W'(eff_nf);
                            node_req.wdata = '{leaf: 1'b1, right: '0,
                                               left: IDX_W'(sh_ext[SYMBOL_BITS-1:0])};
                        end
                        nf_next = nf_inc;
                        if (eff_empty)
                        begin
                            loading_next = 1'b0;
                            cur_rec_next = root_rec;
                        end
                        else
                        begin
                            // Pop the waiting parent; its right child is the next slot
                            stack_req.pop  = 1'b1;
                            start_link     = 1'b1;
                            link_addr_next = stack_stat.top_data;
                            link_rec_next  = '{leaf: 1'b0, right: IDX_W'(nf_inc),
                                               left: stack_stat.top_data + IDX_W'(1)};
                        end
                    end
                end
            end
            else if (eff_emit < symbol_count_reg)
            begin
                // Walk: fetch the chosen child
                node_req.re    = 1'b1;
                node_req.raddr = code_bit ? cur_rec_reg.right : cur_rec_reg.left;
                start_walk     = 1'b1;
            end
        end

        if (raise_err)
        begin
            err_next     = 1'b1;
            res_push     = 1'b1;
            res_data.err = 1'b1;
        end

        // PH_WALK phase of a walk bit: child record is back
        if (walk_done)
        begin
            if (rd_rec.leaf)
            begin
                emitted_next    = emitted_reg + CFG_W'(1);
                res_push        = 1'b1;
                res_data.symbol = rd_rec.left[SYM_W-1:0];
                res_data.last   = ((emitted_reg + CFG_W'(1)) == symbol_count_reg);
                cur_rec_next    = root_rec;
            end
            else
            begin
                cur_rec_next = rd_rec;
            end
        end

        // PH_LINK phase of a closing leaf: link the parent
        if (link_wr)
        begin
            node_req.we    = 1'b1;
            node_req.waddr = link_addr_reg;
            node_req.wdata = link_rec_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            loading_reg      <= 1'b1;
            leaf_cnt_reg     <= '0;
            leaf_shift_reg   <= '0;
            nf_reg           <= '0;
            emitted_reg      <= '0;
            err_reg          <= 1'b0;
            symbol_count_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            loading_reg    <= loading_next;
            leaf_cnt_reg   <= leaf_cnt_next;
            leaf_shift_reg <= leaf_shift_next;
            nf_reg         <= nf_next;
            emitted_reg    <= emitted_next;
            err_reg        <= err_next;
            if (cfg_wr_en)
            begin
                symbol_count_reg <= cfg_wr_data;
            end
        end
    end

    // Walk position and pending link
    always_ff @(posedge clk)
    begin
        cur_rec_reg   <= cur_rec_next;
        link_addr_reg <= link_addr_next;
        link_rec_reg  <= link_rec_next;
    end

endmodule

`default_nettype wire
